// File: rtl/ptb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptb_pkg;

  // Pixel layouts selected by the format register
  typedef enum logic [1:0] {
    FMT_BGRA32  = 2'd0,
    FMT_ARGB32  = 2'd1,
    FMT_RGB565  = 2'd2,
    FMT_RGB1555 = 2'd3
  } ptb_fmt_t;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_FORMAT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RED    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GREEN  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BLUE   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MIX    = 3'd4;

  // Per-item sideband that rides alongside the channel pipelines
  typedef struct packed {
    logic        pass;   // pixel goes out untouched
    logic [31:0] word;   // untouched pixel, upper half cleared for 16-bit layouts
    ptb_fmt_t    fmt;
    logic [7:0]  alpha;
  } ptb_side_t;

  typedef logic [7:0] lut5_t [32];
  typedef logic [7:0] lut6_t [64];

  // v*255/31 and v*255/63, truncating
  function automatic lut5_t build_exp5();
    lut5_t tab;
    for (int i = 0; i < 32; i++) tab[i] = 8'((i * 255) / 31);
    return tab;
  endfunction

  function automatic lut6_t build_exp6();
    lut6_t tab;
    for (int i = 0; i < 64; i++) tab[i] = 8'((i * 255) / 63);
    return tab;
  endfunction

  localparam lut5_t EXP5 = build_exp5();
  localparam lut6_t EXP6 = build_exp6();

endpackage

`default_nettype wire

// File: rtl/pixel_tint_blend.sv
`timescale 1ns / 1ps
`default_nettype none

// Each accepted start yields its done strobe once it has passed through the stages below.
// Throughput: one pixel per cycle; busy stays low, start may be high every cycle.
// Stages: unpack, multiply, sum, divide-by-255, repack.
// The result shows on pixel_out/pixel_changed for the single cycle that done is high.
// Reset (rst, synchronous) clears the pipeline valid bits and all tint registers.
module pixel_tint_blend import ptb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // pixel transactions
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [31:0]        pixel_in,
  output logic                    done,
  output logic [31:0]             pixel_out,
  output logic                    pixel_changed,
  // register writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [7:0]         cfg_data
);

  // Config registers. The user must change them only while no transaction is
  // in flight (the block does not enforce this), as the stages read them directly.
  ptb_fmt_t   pixel_format;
  logic [7:0] tint_red;
  logic [7:0] tint_green;
  logic [7:0] tint_blue;
  logic [7:0] tint_mix;

  // Pipeline never stalls: the receiver must take every result; the block does not wait.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_BGRA32;
      tint_red     <= 8'd0;
      tint_green   <= 8'd0;
      tint_blue    <= 8'd0;
      tint_mix     <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FORMAT: pixel_format <= ptb_fmt_t'(cfg_data[1:0]);
        REG_RED:    tint_red     <= cfg_data;
        REG_GREEN:  tint_green   <= cfg_data;
        REG_BLUE:   tint_blue    <= cfg_data;
        REG_MIX:    tint_mix     <= cfg_data;
        default:    ;  // writes past the register list are dropped
      endcase
    end
  end

  // Stage 1: unpack
  logic       s1_valid;
  logic [7:0] s1_red, s1_green, s1_blue;
  ptb_side_t  s1_side;

  ptb_unpack u_unpack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .px        (pixel_in),
    .fmt       (pixel_format),
    .mix       (tint_mix),
    .out_valid (s1_valid),
    .red       (s1_red),
    .green     (s1_green),
    .blue      (s1_blue),
    .side      (s1_side)
  );

  // Stages 2-4: one blend lane per color channel
  logic [7:0] s4_red, s4_green, s4_blue;

  ptb_chan_blend u_blend_r (
    .clk(clk), .chan(s1_red),   .tint(tint_red),   .mix(tint_mix), .blended(s4_red)
  );
  ptb_chan_blend u_blend_g (
    .clk(clk), .chan(s1_green), .tint(tint_green), .mix(tint_mix), .blended(s4_green)
  );
  ptb_chan_blend u_blend_b (
    .clk(clk), .chan(s1_blue),  .tint(tint_blue),  .mix(tint_mix), .blended(s4_blue)
  );

  // Sideband and valid follow the lanes through the same three stages
  logic      s2_valid, s3_valid, s4_valid;
  ptb_side_t s2_side, s3_side, s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_side <= s1_side;
    s3_side <= s2_side;
    s4_side <= s3_side;
  end

  // Stage 5: repack and output register
  ptb_pack u_pack (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s4_valid),
    .red           (s4_red),
    .green         (s4_green),
    .blue          (s4_blue),
    .side          (s4_side),
    .done          (done),
    .pixel_out     (pixel_out),
    .pixel_changed (pixel_changed)
  );

`ifndef SYNTHESIS
  // every accepted pixel yields exactly one strobe once it has passed through the pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("done missing 5 cycles after start");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("done without a matching start");

  // mix of zero turns tinting off for every pixel
  a_mix_off: assert property (@(posedge clk) disable iff (rst)
    (done && tint_mix == 8'd0) |-> !pixel_changed)
    else $error("pixel rewritten with zero mix");

  // 16-bit layouts leave the upper half clear
  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (pixel_format == FMT_RGB565 || pixel_format == FMT_RGB1555))
      |-> (pixel_out[31:16] == 16'd0))
    else $error("upper half set in 16-bit layout");

  // a rewritten RGB1555 pixel stays opaque
  a_1555_opaque: assert property (@(posedge clk) disable iff (rst)
    (done && pixel_changed && pixel_format == FMT_RGB1555) |-> pixel_out[15])
    else $error("rewritten RGB1555 pixel lost alpha");
`endif

endmodule

`default_nettype wire

// File: rtl/ptb_unpack.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 1: split the pixel into 8-bit channels and decide pass-through.
module ptb_unpack import ptb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [31:0] px,
  input  wire ptb_fmt_t    fmt,
  input  wire logic [7:0]  mix,
  output logic             out_valid,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output ptb_side_t        side
);

  logic [7:0] r_c, g_c, b_c, a_c;
  ptb_side_t  side_c;

  always_comb begin
    r_c = 8'd0;
    g_c = 8'd0;
    b_c = 8'd0;
    a_c = 8'd0;
    case (fmt)
      FMT_BGRA32: begin
        b_c = px[7:0];
        g_c = px[15:8];
        r_c = px[23:16];
        a_c = px[31:24];
      end
      FMT_ARGB32: begin
        a_c = px[7:0];
        r_c = px[15:8];
        g_c = px[23:16];
        b_c = px[31:24];
      end
      FMT_RGB565: begin
        r_c = EXP5[px[15:11]];
        g_c = EXP6[px[10:5]];
        b_c = EXP5[px[4:0]];
        a_c = 8'hff;
      end
      FMT_RGB1555: begin
        r_c = EXP5[px[14:10]];
        g_c = EXP5[px[9:5]];
        b_c = EXP5[px[4:0]];
        a_c = px[15] ? 8'hff : 8'h00;
      end
      default: begin
        a_c = 8'd0;
      end
    endcase
  end

  always_comb begin
    side_c.pass  = (mix == 8'd0) || (a_c == 8'd0);
    side_c.word  = (fmt == FMT_RGB565 || fmt == FMT_RGB1555) ? {16'd0, px[15:0]} : px;
    side_c.fmt   = fmt;
    side_c.alpha = a_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    red   <= r_c;
    green <= g_c;
    blue  <= b_c;
    side  <= side_c;
  end

endmodule

`default_nettype wire

// File: rtl/ptb_chan_blend.sv
`timescale 1ns / 1ps
`default_nettype none

// Stages 2-4 for one channel: multiply, sum, divide by 255.
module ptb_chan_blend (
  input  wire logic       clk,
  input  wire logic [7:0] chan,
  input  wire logic [7:0] tint,
  input  wire logic [7:0] mix,
  output logic [7:0]      blended
);

  logic [15:0] prod_c, prod_t;
  logic [15:0] sum;
  logic [16:0] div_acc;

  // x/255 == (x + (x>>8) + 1) >> 8 for every x below 65535; the sum here
  // never exceeds 255*255
  assign div_acc = {1'b0, sum} + {9'd0, sum[15:8]} + 17'd1;

  always_ff @(posedge clk) begin
    prod_c  <= chan * (8'd255 - mix);
    prod_t  <= tint * mix;
    sum     <= prod_c + prod_t;
    blended <= div_acc[15:8];
  end

endmodule

`default_nettype wire

// File: rtl/ptb_pack.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 5: repack channels into the pixel layout, register the result.
module ptb_pack import ptb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  input  wire ptb_side_t  side,
  output logic            done,
  output logic [31:0]     pixel_out,
  output logic            pixel_changed
);

  logic [31:0] packed_c;

  always_comb begin
    case (side.fmt)
      FMT_BGRA32:  packed_c = {side.alpha, red, green, blue};
      FMT_ARGB32:  packed_c = {blue, green, red, side.alpha};
      FMT_RGB565:  packed_c = {16'd0, red[7:3], green[7:2], blue[7:3]};
      FMT_RGB1555: packed_c = {16'd0, side.alpha[7], red[7:3], green[7:3], blue[7:3]};
      default:     packed_c = side.word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pixel_out     <= side.pass ? side.word : packed_c;
    pixel_changed <= ~side.pass;
  end

endmodule

`default_nettype wire
